@@ sv/ssi_pkg.sv @@
// shared types, sizes and helpers of the sorted set unit
`timescale 1ns / 1ps
`default_nettype none
package ssi_pkg;

  localparam int CAPACITY = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;
  localparam int OPC_W    = 2;
  localparam int STAT_W   = 3;
  localparam int SCNT_W   = 6;

  typedef enum logic [OPC_W-1:0] {
    OP_INSERT    = 2'd0,
    OP_DELETE    = 2'd1,
    OP_LIST_DESC = 2'd2,
    OP_LIST_ASC  = 2'd3
  } opcode_t;

  typedef enum logic [STAT_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_REMOVED   = 3'd2,
    ST_NOTFOUND  = 3'd3,
    ST_EMPTY     = 3'd4,
    ST_FULL      = 3'd5,
    ST_ELEMENT   = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    K_INSERT = 2'd0,
    K_DELETE = 2'd1,
    K_LIST   = 2'd2
  } kind_t;

  // classified command handed from front to back
  typedef struct packed {
    kind_t                    kind;
    logic                     ascending;
    logic signed [VAL_W-1:0]  value;
  } cmd_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_SRD,
    B_SCHK,
    B_ISH_RD,
    B_ISH_WR,
    B_DSH_RD,
    B_DSH_WR,
    B_LRD,
    B_LEM,
    B_FIN
  } bstate_t;

  // count reported in the result, kept to its low bits
  function automatic logic [SCNT_W-1:0] count_field(input logic [CNT_W-1:0] c);
    logic [CNT_W+SCNT_W-1:0] e;
    e = {{SCNT_W{1'b0}}, c};
    return e[SCNT_W-1:0];
  endfunction

endpackage
`default_nettype wire

@@ sv/ssi_if.sv @@
// valid/ready channel interfaces for commands and results
`timescale 1ns / 1ps
`default_nettype none
interface ssi_in_if import ssi_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [OPC_W-1:0]        opcode;
  logic signed [VAL_W-1:0] operand_value;

  modport source (output valid, output opcode, output operand_value, input ready);
  modport sink   (input valid, input opcode, input operand_value, output ready);
endinterface

interface ssi_out_if import ssi_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [STAT_W-1:0]       status;
  logic signed [VAL_W-1:0] element_value;
  logic [SCNT_W-1:0]       stored_count;
  logic                    last;

  modport source (output valid, output status, output element_value, output stored_count,
                  output last, input ready);
  modport sink   (input valid, input status, input element_value, input stored_count,
                  input last, output ready);
endinterface
`default_nettype wire

@@ sv/ssi_front.sv @@
// front end: accepts items, decodes the opcode and queues commands
`timescale 1ns / 1ps
`default_nettype none
module ssi_front import ssi_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  ssi_in_if.sink in_ch,
  output logic   cmd_valid,
  output cmd_t   cmd,
  input  logic   cmd_pop
);

  cmd_t       q_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] fill_r, fill_nxt;
  logic       push;
  cmd_t       dec;

  assign in_ch.ready = (fill_r != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign cmd_valid   = (fill_r != 2'd0);
  assign cmd         = q_r[rp_r];

  // list commands carry a zero operand, the echo of an empty listing
  always_comb begin
    dec.value     = in_ch.operand_value;
    dec.ascending = 1'b0;
    unique case (opcode_t'(in_ch.opcode))
      OP_INSERT:    dec.kind = K_INSERT;
      OP_DELETE:    dec.kind = K_DELETE;
      OP_LIST_DESC: begin
        dec.kind  = K_LIST;
        dec.value = '0;
      end
      OP_LIST_ASC: begin
        dec.kind      = K_LIST;
        dec.ascending = 1'b1;
        dec.value     = '0;
      end
      default: begin
        dec.kind  = K_LIST;
        dec.value = '0;
      end
    endcase
  end

  always_comb begin
    wp_nxt   = push ? ~wp_r : wp_r;
    rp_nxt   = cmd_pop ? ~rp_r : rp_r;
    fill_nxt = fill_r + {1'b0, push} - {1'b0, cmd_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= 1'b0;
      rp_r   <= 1'b0;
      fill_r <= 2'd0;
    end else begin
      wp_r   <= wp_nxt;
      rp_r   <= rp_nxt;
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= dec;
  end

endmodule
`default_nettype wire

@@ sv/ssi_back.sv @@
// back end: ordered store, search and shift sequencer, result register
`timescale 1ns / 1ps
`default_nettype none
module ssi_back import ssi_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cmd_valid,
  input  cmd_t      cmd,
  output logic      cmd_pop,
  ssi_out_if.source out_ch
);

  logic signed [VAL_W-1:0] mem [CAPACITY];
  logic signed [VAL_W-1:0] mem_q;
  logic                    we, re;
  logic [IDX_W-1:0]        waddr, raddr;
  logic signed [VAL_W-1:0] wdata;

  bstate_t                 state_r, state_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [CNT_W-1:0]        idx_r, idx_nxt;
  logic [CNT_W-1:0]        pos_r, pos_nxt;
  logic signed [VAL_W-1:0] v_r, v_nxt;
  kind_t                   kind_r, kind_nxt;
  logic                    asc_r, asc_nxt;
  status_t                 st_r, st_nxt;

  logic                    out_valid_r, out_valid_nxt;
  status_t                 out_st_r, out_st_nxt;
  logic signed [VAL_W-1:0] out_val_r, out_val_nxt;
  logic [SCNT_W-1:0]       out_cnt_r, out_cnt_nxt;
  logic                    out_last_r, out_last_nxt;

  logic                    slot_free, idx_end, full, hit, below, cnt_zero;
  logic [CNT_W-1:0]        idx_inc, idx_dec, list_idx;

  assign slot_free = !out_valid_r || out_ch.ready;
  assign idx_end   = (idx_r == count_r);
  assign full      = (count_r == CNT_W'(CAPACITY));
  assign cnt_zero  = (count_r == '0);
  assign hit       = (mem_q == v_r);
  assign below     = (mem_q < v_r);
  assign idx_inc   = idx_r + 1'b1;
  assign idx_dec   = idx_r - 1'b1;
  assign list_idx  = asc_r ? (count_r - 1'b1 - idx_r) : idx_r;

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_st_r;
  assign out_ch.element_value = out_val_r;
  assign out_ch.stored_count  = out_cnt_r;
  assign out_ch.last          = out_last_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: begin
        if (cmd_valid) begin
          if (cnt_zero && cmd.kind != K_INSERT) state_nxt = B_FIN;
          else if (cmd.kind == K_LIST)          state_nxt = B_LRD;
          else                                  state_nxt = B_SRD;
        end
      end
      B_SRD: begin
        if (!idx_end)                           state_nxt = B_SCHK;
        else if (kind_r == K_INSERT && !full)   state_nxt = B_ISH_RD;
        else                                    state_nxt = B_FIN;
      end
      B_SCHK: begin
        if (hit)        state_nxt = (kind_r == K_DELETE) ? B_DSH_RD : B_FIN;
        else if (below) state_nxt = (kind_r == K_INSERT && !full) ? B_ISH_RD : B_FIN;
        else            state_nxt = B_SRD;
      end
      B_ISH_RD: state_nxt = (idx_r == pos_r) ? B_FIN : B_ISH_WR;
      B_ISH_WR: state_nxt = B_ISH_RD;
      B_DSH_RD: state_nxt = (idx_inc == count_r) ? B_FIN : B_DSH_WR;
      B_DSH_WR: state_nxt = B_DSH_RD;
      B_LRD:    state_nxt = B_LEM;
      B_LEM: begin
        if (slot_free) state_nxt = (idx_inc == count_r) ? B_IDLE : B_LRD;
      end
      B_FIN: begin
        if (slot_free) state_nxt = B_IDLE;
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    pos_nxt       = pos_r;
    v_nxt         = v_r;
    kind_nxt      = kind_r;
    asc_nxt       = asc_r;
    st_nxt        = st_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_st_nxt    = out_st_r;
    out_val_nxt   = out_val_r;
    out_cnt_nxt   = out_cnt_r;
    out_last_nxt  = out_last_r;
    cmd_pop       = 1'b0;
    we            = 1'b0;
    re            = 1'b0;
    waddr         = '0;
    raddr         = '0;
    wdata         = '0;
    unique case (state_r)
      B_IDLE: begin
        if (cmd_valid) begin
          cmd_pop  = 1'b1;
          kind_nxt = cmd.kind;
          asc_nxt  = cmd.ascending;
          v_nxt    = cmd.value;
          idx_nxt  = '0;
          st_nxt   = ST_EMPTY;
        end
      end
      B_SRD: begin
        if (!idx_end) begin
          re    = 1'b1;
          raddr = idx_r[IDX_W-1:0];
        end else if (kind_r == K_INSERT) begin
          if (full) st_nxt = ST_FULL;
          else      pos_nxt = count_r;
        end else begin
          st_nxt = ST_NOTFOUND;
        end
      end
      B_SCHK: begin
        if (hit) begin
          if (kind_r == K_DELETE) pos_nxt = idx_r;
          else                    st_nxt  = ST_DUPLICATE;
        end else if (below) begin
          if (kind_r == K_DELETE) begin
            st_nxt = ST_NOTFOUND;
          end else if (full) begin
            st_nxt = ST_FULL;
          end else begin
            pos_nxt = idx_r;
            idx_nxt = count_r;
          end
        end else begin
          idx_nxt = idx_inc;
        end
      end
      B_ISH_RD: begin
        if (idx_r == pos_r) begin
          we        = 1'b1;
          waddr     = pos_r[IDX_W-1:0];
          wdata     = v_r;
          count_nxt = count_r + 1'b1;
          st_nxt    = ST_INSERTED;
        end else begin
          re    = 1'b1;
          raddr = idx_dec[IDX_W-1:0];
        end
      end
      B_ISH_WR: begin
        we      = 1'b1;
        waddr   = idx_r[IDX_W-1:0];
        wdata   = mem_q;
        idx_nxt = idx_dec;
      end
      B_DSH_RD: begin
        if (idx_inc == count_r) begin
          count_nxt = count_r - 1'b1;
          st_nxt    = ST_REMOVED;
        end else begin
          re    = 1'b1;
          raddr = idx_inc[IDX_W-1:0];
        end
      end
      B_DSH_WR: begin
        we      = 1'b1;
        waddr   = idx_r[IDX_W-1:0];
        wdata   = mem_q;
        idx_nxt = idx_inc;
      end
      B_LRD: begin
        re    = 1'b1;
        raddr = list_idx[IDX_W-1:0];
      end
      B_LEM: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_st_nxt    = ST_ELEMENT;
          out_val_nxt   = mem_q;
          out_cnt_nxt   = count_field(count_r);
          out_last_nxt  = (idx_inc == count_r);
          idx_nxt       = idx_inc;
        end
      end
      B_FIN: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_st_nxt    = st_r;
          out_val_nxt   = v_r;
          out_cnt_nxt   = count_field(count_r);
          out_last_nxt  = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    pos_r      <= pos_nxt;
    v_r        <= v_nxt;
    kind_r     <= kind_nxt;
    asc_r      <= asc_nxt;
    st_r       <= st_nxt;
    out_st_r   <= out_st_nxt;
    out_val_r  <= out_val_nxt;
    out_cnt_r  <= out_cnt_nxt;
    out_last_r <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (re) mem_q <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ sv/sorted_set_insert_delete_unit.sv @@
// top level of the sorted set unit: front end, command queue and back end
// insert and delete scan the entries in order and then shift them, each entry read before
//   it is checked or written, since the store has one read port with a registered output
// list: each element is read from the store and then registered as a result
// throughput: one item at a time in the back end, a 2-deep queue absorbs new items
// reset: clears the entry count, the queue and the result valid; the store itself
//   is not cleared, entries past the count are never read
`timescale 1ns / 1ps
`default_nettype none
module sorted_set_insert_delete_unit import ssi_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  ssi_in_if.sink    in_ch,
  ssi_out_if.source out_ch
);

  // classified commands waiting for the back end
  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;

  // front: decode opcode, buffer up to two commands
  ssi_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  // back: search the descending store, shift entries, emit results
  ssi_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .out_ch    (out_ch)
  );

`ifndef SYNTHESIS
  // the back end never takes from an empty queue
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> cmd_valid) else $error("command popped from empty queue");

  // a popped command keeps the back end busy, so no pop follows in the next cycle
  a_pop_gap: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |=> !cmd_pop) else $error("back-to-back command pops");

  // only element results may be followed by more results of the same item
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status != ST_ELEMENT) |-> out_ch.last)
    else $error("non-element result without last");

  // no result right after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid) else $error("result valid after reset");
`endif

endmodule
`default_nettype wire

@@ tb/tb_sorted_set_insert_delete_unit.sv @@
// self-checking testbench of the sorted set unit with its own set predictor
`timescale 1ns / 1ps
module tb_sorted_set_insert_delete_unit;
  import ssi_pkg::*;

  // run limit in ns, many times the slowest legal run of this stimulus
  localparam longint RUN_LIMIT_NS = 64'd10_000_000;
  // cycles allowed after the last awaited result for stray items
  localparam int TAIL_CYCLES = 100;

  // one command item as queued for the driver
  typedef struct {
    opcode_t                 op;
    logic signed [VAL_W-1:0] value;
    logic                    wait_drain;  // hold until all results are back
  } set_cmd_t;

  // one result item as predicted
  typedef struct {
    status_t                 status;
    logic signed [VAL_W-1:0] value;
    logic [SCNT_W-1:0]       count;
    logic                    last;
  } set_result_t;

  // ready patterns of the result side
  typedef enum int {
    RDY_ALWAYS,
    RDY_THIRD,
    RDY_COIN,
    RDY_PATTERN
  } ready_mode_t;

  logic clk;
  logic rst_n;

  ssi_in_if  in_ch ();
  ssi_out_if out_ch ();

  sorted_set_insert_delete_unit DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  set_cmd_t                pending_cmds[$];     // items not yet offered
  set_result_t             awaited_results[$];  // results still to come, oldest first
  logic signed [VAL_W-1:0] held_values[$];      // predicted set, descending
  logic signed [VAL_W-1:0] gen_pool[$];         // values inserted by the generator
  int                      fault_count = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic log_fault(input string what);
    $display("[%0t] fault: %s", $time, what);
    fault_count++;
  endtask

  task automatic await_result(input status_t st, input logic signed [VAL_W-1:0] v,
                              input logic is_last);
    set_result_t r;
    r.status = st;
    r.value  = v;
    r.count  = SCNT_W'(held_values.size());
    r.last   = is_last;
    awaited_results.push_back(r);
  endtask

  // apply one accepted command to the predicted set and queue its results
  task automatic apply_set_op(input opcode_t op, input logic signed [VAL_W-1:0] v);
    int pos;
    int n;
    pos = -1;
    foreach (held_values[i])
      if (pos < 0 && held_values[i] == v) pos = i;
    n = held_values.size();
    case (op)
      OP_INSERT: begin
        // duplicate wins over full
        if (pos >= 0) begin
          await_result(ST_DUPLICATE, v, 1'b1);
        end else if (n >= CAPACITY) begin
          await_result(ST_FULL, v, 1'b1);
        end else begin
          pos = 0;
          while (pos < n && !(v > held_values[pos])) pos++;
          held_values.insert(pos, v);
          await_result(ST_INSERTED, v, 1'b1);
        end
      end
      OP_DELETE: begin
        if (n == 0) begin
          await_result(ST_EMPTY, v, 1'b1);
        end else if (pos < 0) begin
          await_result(ST_NOTFOUND, v, 1'b1);
        end else begin
          held_values.delete(pos);
          await_result(ST_REMOVED, v, 1'b1);
        end
      end
      default: begin
        // listing an empty set still gives one result
        if (n == 0) begin
          await_result(ST_EMPTY, '0, 1'b1);
        end else begin
          for (int i = 0; i < n; i++)
            await_result(ST_ELEMENT,
                         (op == OP_LIST_DESC) ? held_values[i] : held_values[n-1-i],
                         i == n - 1);
        end
      end
    endcase
  endtask

  task automatic queue_cmd(input opcode_t op, input logic signed [VAL_W-1:0] v,
                           input logic hold);
    set_cmd_t c;
    c.op         = op;
    c.value      = v;
    c.wait_drain = hold;
    pending_cmds.push_back(c);
    if (op == OP_INSERT) gen_pool.push_back(v);
  endtask

  // extremes, alternating bits, small values and full random words
  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return $urandom_range(0, 1) ? 32'shaaaa_aaaa : 32'sh5555_5555;
      3, 4:    return $signed($urandom_range(0, 12)) - 6;
      default: return $urandom;
    endcase
  endfunction

  // value that likely hits the set: an earlier inserted value, small value or anything
  function automatic logic signed [VAL_W-1:0] pick_hit_value();
    int k;
    k = $urandom_range(0, 9);
    if (k < 4 && gen_pool.size() > 0) return gen_pool[$urandom_range(0, gen_pool.size() - 1)];
    if (k < 8) return $signed($urandom_range(0, 12)) - 6;
    return pick_value();
  endfunction

  task automatic build_stimulus();
    int idx;
    opcode_t op;
    // directed: empty set handling, extremes, duplicates, both list orders
    queue_cmd(OP_LIST_DESC, 32'sh0, 1'b0);
    queue_cmd(OP_LIST_ASC, 32'sh1234_5678, 1'b0);   // operand ignored
    queue_cmd(OP_DELETE, 32'sh8000_0000, 1'b0);     // delete from empty set
    queue_cmd(OP_INSERT, 32'sh0, 1'b0);
    queue_cmd(OP_INSERT, 32'sh7fff_ffff, 1'b0);
    queue_cmd(OP_INSERT, 32'sh8000_0000, 1'b0);
    queue_cmd(OP_INSERT, -32'sd1, 1'b0);
    queue_cmd(OP_INSERT, 32'sd1, 1'b0);
    queue_cmd(OP_INSERT, 32'shaaaa_aaaa, 1'b0);
    queue_cmd(OP_INSERT, 32'sh5555_5555, 1'b0);
    queue_cmd(OP_INSERT, 32'sh0, 1'b0);             // duplicate
    queue_cmd(OP_INSERT, 32'sh7fff_ffff, 1'b0);     // duplicate at the top
    queue_cmd(OP_DELETE, 32'sd5, 1'b0);             // absent value
    queue_cmd(OP_LIST_DESC, -32'sd1, 1'b0);
    queue_cmd(OP_LIST_ASC, 32'sh0, 1'b0);
    queue_cmd(OP_DELETE, 32'sh7fff_ffff, 1'b0);     // head
    queue_cmd(OP_DELETE, 32'sh8000_0000, 1'b0);     // tail
    queue_cmd(OP_DELETE, 32'sh0, 1'b0);             // middle
    queue_cmd(OP_DELETE, 32'shaaaa_aaaa, 1'b0);
    queue_cmd(OP_DELETE, 32'sh5555_5555, 1'b0);
    queue_cmd(OP_LIST_ASC, 32'sh0, 1'b0);
    queue_cmd(OP_DELETE, -32'sd1, 1'b0);
    queue_cmd(OP_DELETE, 32'sd1, 1'b0);             // set runs empty
    queue_cmd(OP_DELETE, 32'sd1, 1'b0);             // delete from empty set again
    queue_cmd(OP_LIST_DESC, 32'sh0, 1'b0);
    gen_pool.delete();

    // fill past capacity: full rejects, a duplicate on a full set, both lists
    for (int i = 0; i < 36; i++)
      queue_cmd(OP_INSERT, (i % 9 == 8) ? pick_value() : $urandom, i == 0);
    queue_cmd(OP_INSERT, gen_pool[$urandom_range(0, 31)], 1'b0);
    queue_cmd(OP_LIST_DESC, $urandom, 1'b0);
    queue_cmd(OP_LIST_ASC, $urandom, 1'b0);

    // drain most of it again, with a few misses
    for (int i = 0; i < 22; i++) begin
      if ($urandom_range(0, 5) == 0 || gen_pool.size() == 0) begin
        queue_cmd(OP_DELETE, pick_value(), i == 0);
      end else begin
        idx = $urandom_range(0, gen_pool.size() - 1);
        queue_cmd(OP_DELETE, gen_pool[idx], i == 0);
        gen_pool.delete(idx);
      end
    end
    queue_cmd(OP_LIST_ASC, 32'sh0, 1'b0);

    // mixed rounds on a small value range so hits and misses both occur
    while (pending_cmds.size() < 165) begin
      for (int i = 0; i < 20; i++) begin
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4, 5, 6, 7: op = OP_INSERT;
          8, 9, 10, 11, 12, 13, 14: op = OP_DELETE;
          15, 16: op = OP_LIST_DESC;
          default: op = OP_LIST_ASC;
        endcase
        queue_cmd(op, pick_hit_value(), i == 0);
      end
    end
  endtask

  // driver: bursts of items with random gaps, some stretches without gaps
  always @(posedge clk) begin : drive_items
    logic     fire;
    logic     next_valid;
    set_cmd_t cmd;
    int       burst_left;
    int       gap_left;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      fire = in_ch.valid && in_ch.ready;
      if (fire) apply_set_op(opcode_t'(in_ch.opcode), in_ch.operand_value);
      // an item not yet taken stays on the bus untouched
      if (!in_ch.valid || fire) begin
        next_valid = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_cmds.size() > 0 &&
                     !(pending_cmds[0].wait_drain && awaited_results.size() != 0)) begin
          cmd = pending_cmds.pop_front();
          in_ch.opcode        <= cmd.op;
          in_ch.operand_value <= cmd.value;
          next_valid = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 12);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
        in_ch.valid <= next_valid;
      end
    end
  end

  // monitor: checks each taken result and drives ready on changing patterns
  always @(posedge clk) begin : check_results
    set_result_t want;
    ready_mode_t mode;
    int          mode_left;
    int          cyc;
    logic        rdy;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      mode      = RDY_ALWAYS;
      mode_left = 0;
      cyc       = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (awaited_results.size() == 0) begin
          log_fault($sformatf("result with nothing awaited: status %0d value %0d",
                              out_ch.status, out_ch.element_value));
        end else begin
          want = awaited_results.pop_front();
          if (out_ch.status !== want.status)
            log_fault($sformatf("status %0d, wanted %0d", out_ch.status, want.status));
          if (out_ch.element_value !== want.value)
            log_fault($sformatf("element_value %0d, wanted %0d",
                                out_ch.element_value, want.value));
          if (out_ch.stored_count !== want.count)
            log_fault($sformatf("stored_count %0d, wanted %0d",
                                out_ch.stored_count, want.count));
          if (out_ch.last !== want.last)
            log_fault($sformatf("last %0b, wanted %0b", out_ch.last, want.last));
        end
      end
      // switch the stall pattern when its random run length is used up
      if (mode_left == 0) begin
        mode      = ready_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 80);
      end else begin
        mode_left--;
      end
      cyc++;
      case (mode)
        RDY_ALWAYS: rdy = 1'b1;
        RDY_THIRD:  rdy = (cyc % 3 == 0);
        RDY_COIN:   rdy = 1'($urandom_range(0, 1));
        default:    rdy = 1'(8'b1011_0010 >> (cyc % 8));
      endcase
      out_ch.ready <= rdy;
    end
  end

  initial begin
    clk                 = 1'b0;
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.opcode        = '0;
    in_ch.operand_value = '0;
    out_ch.ready        = 1'b0;
    build_stimulus();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    // all items offered and taken, then every result back
    while (pending_cmds.size() != 0 || in_ch.valid) @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
    // room for any stray result to show up
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fault_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // hang guard
  initial begin
    #(RUN_LIMIT_NS);
    $display("[%0t] run limit reached, %0d results outstanding", $time,
             awaited_results.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

@@ files.f @@
sv/ssi_pkg.sv
sv/ssi_if.sv
sv/ssi_front.sv
sv/ssi_back.sv
sv/sorted_set_insert_delete_unit.sv
tb/tb_sorted_set_insert_delete_unit.sv
